FILE: rtl/ucps_pkg.sv
package ucps_pkg;

    localparam int OFFSET_WIDTH_DEF = 16;
    localparam int CHAR_OFFSET_W    = 16;
    localparam int CHAR_LENGTH_W    = 3;
    localparam int BYTE_W           = 8;
    localparam int ENC_W            = 2;
    localparam int SKIP_W           = 3;
    localparam int UNIT_IDX_W       = 2;
    localparam int GATHER_W         = 24;
    localparam int APB_DATA_W       = 32;
    localparam int APB_ADDR_W       = 3;

    localparam logic [ENC_W-1:0] ENC_UTF8  = 2'd0;
    localparam logic [ENC_W-1:0] ENC_UTF16 = 2'd1;
    localparam logic [ENC_W-1:0] ENC_UTF32 = 2'd2;

    localparam logic REG_ENCODING   = 1'b0;
    localparam logic REG_BIG_ENDIAN = 1'b1;

    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;

    localparam logic [UNIT_IDX_W-1:0] UNIT_IDX_LAST32 = 2'd3;

    localparam logic [CHAR_LENGTH_W-1:0] LEN_UNIT16 = 3'd2;
    localparam logic [CHAR_LENGTH_W-1:0] LEN_UNIT32 = 3'd4;
    localparam logic [SKIP_W-1:0]        SKIP_SURR  = 3'd2;

    typedef struct packed {
        logic [ENC_W-1:0] encoding;
        logic             big_endian;
    } t_cfg;

    typedef struct packed {
        logic                     valid;
        logic [CHAR_OFFSET_W-1:0] char_offset;
        logic [CHAR_LENGTH_W-1:0] char_length;
    } t_result;

    function automatic logic [SKIP_W-1:0] utf8_trailing(input logic [BYTE_W-1:0] b);
        logic [SKIP_W-1:0] t;
        begin
            if (b < 8'hC0)      t = 3'd0;
            else if (b < 8'hE0) t = 3'd1;
            else if (b < 8'hF0) t = 3'd2;
            else if (b < 8'hF8) t = 3'd3;
            else if (b < 8'hFC) t = 3'd4;
            else                t = 3'd5;
            return t;
        end
    endfunction

endpackage

FILE: rtl/ucps_if.sv
interface ucps_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       string_start;

    modport source (output valid, output byte_value, output string_start, input ready);
    modport sink   (input valid, input byte_value, input string_start, output ready);
endinterface

interface ucps_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] char_offset;
    logic [2:0]  char_length;

    modport source (output valid, output char_offset, output char_length, input ready);
    modport sink   (input valid, input char_offset, input char_length, output ready);
endinterface

FILE: rtl/unicode_code_point_splitter.sv
// Channel   Dir  Word                          Handshake
// i_in      in   byte_value[7:0], string_start valid/ready
// o_out     out  char_offset[15:0], char_length[2:0] valid/ready
// apb       in   encoding @0x0, big_endian @0x4 psel/penable, pready tied high
//
// One byte per cycle unless o_out stalls; bytes pass input reg, step logic, result reg.
// Rate is set by the input register and result register pair around the step logic.
// i_rst_n is synchronous, active low; it clears both registers, all parse state and config.
// A stalled o_out holds the input register, and i_in stalls only when both are full.
module unicode_code_point_splitter #(
    parameter int OFFSET_WIDTH = ucps_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    ucps_in_if.sink                           i_in,
    ucps_out_if.source                        o_out,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ucps_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ucps_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ucps_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import ucps_pkg::*;

    t_cfg                     r_cfg;
    logic                     r_in_valid;
    logic [BYTE_W-1:0]        r_in_byte;
    logic                     r_in_start;
    logic                     r_out_valid;
    logic [CHAR_OFFSET_W-1:0] r_out_off;
    logic [CHAR_LENGTH_W-1:0] r_out_len;
    logic                     adv;
    logic                     reg_sel;
    t_result                  res;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];

    always_comb begin
        case (reg_sel)
            REG_ENCODING:   prdata = APB_DATA_W'(r_cfg.encoding);
            REG_BIG_ENDIAN: prdata = APB_DATA_W'(r_cfg.big_endian);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_sel)
                REG_ENCODING:   r_cfg.encoding   <= pwdata[ENC_W-1:0];
                REG_BIG_ENDIAN: r_cfg.big_endian <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in_byte  <= i_in.byte_value;
            r_in_start <= i_in.string_start;
        end
    end

    ucps_step #(
        .OFFSET_WIDTH(OFFSET_WIDTH)
    ) u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (adv),
        .i_byte  (r_in_byte),
        .i_start (r_in_start),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= res.valid;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && res.valid) begin
            r_out_off <= res.char_offset;
            r_out_len <= res.char_length;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.char_offset = r_out_off;
    assign o_out.char_length = r_out_len;

endmodule

FILE: rtl/ucps_step.sv
module ucps_step #(
    parameter int OFFSET_WIDTH = ucps_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_fire,
    input  logic [ucps_pkg::BYTE_W-1:0]  i_byte,
    input  logic                         i_start,
    input  ucps_pkg::t_cfg               i_cfg,
    output ucps_pkg::t_result            o_res
);
    import ucps_pkg::*;

    localparam logic [OFFSET_WIDTH-1:0] POS_MAX = {OFFSET_WIDTH{1'b1}};

    logic [OFFSET_WIDTH-1:0] r_pos, n_pos;
    logic [SKIP_W-1:0]       r_skip, n_skip;
    logic [UNIT_IDX_W-1:0]   r_idx, n_idx;
    logic [GATHER_W-1:0]     r_gather, n_gather;
    logic [OFFSET_WIDTH-1:0] r_ustart, n_ustart;
    logic                    r_stop, n_stop;

    logic [OFFSET_WIDTH-1:0] pos, ustart, ustart_eff, emit_off;
    logic [SKIP_W-1:0]       skip, trail;
    logic [UNIT_IDX_W-1:0]   idx;
    logic [GATHER_W-1:0]     gather, shifted;
    logic                    stop;
    logic [15:0]             unit;
    logic                    emit;
    logic [CHAR_LENGTH_W-1:0] emit_len;

    always_comb begin
        pos    = i_start ? '0 : r_pos;
        skip   = i_start ? '0 : r_skip;
        idx    = i_start ? '0 : r_idx;
        gather = i_start ? '0 : r_gather;
        ustart = i_start ? '0 : r_ustart;
        stop   = i_start ? 1'b0 : r_stop;

        n_pos    = pos;
        n_skip   = skip;
        n_idx    = idx;
        n_gather = gather;
        n_ustart = ustart;
        n_stop   = stop;

        trail      = utf8_trailing(i_byte);
        shifted    = {gather[GATHER_W-BYTE_W-1:0], i_byte};
        ustart_eff = (idx == '0) ? pos : ustart;
        unit       = i_cfg.big_endian ? {gather[BYTE_W-1:0], i_byte}
                                      : {i_byte, gather[BYTE_W-1:0]};
        emit       = 1'b0;
        emit_off   = pos;
        emit_len   = '0;

        if (!stop) begin
            if (pos != POS_MAX) n_pos = pos + OFFSET_WIDTH'(1);
            if (skip != '0) begin
                n_skip = skip - SKIP_W'(1);
            end else begin
                case (i_cfg.encoding)
                    ENC_UTF8: begin
                        n_idx = '0;
                        if (i_byte == '0) begin
                            n_stop = 1'b1;
                        end else begin
                            n_skip   = trail;
                            emit     = 1'b1;
                            emit_len = CHAR_LENGTH_W'(trail) + CHAR_LENGTH_W'(1);
                        end
                    end
                    ENC_UTF16, ENC_UTF32: begin
                        n_ustart = ustart_eff;
                        n_gather = shifted;
                        emit_off = ustart_eff;
                        if (i_cfg.encoding == ENC_UTF16 && idx != '0) begin
                            n_idx = '0;
                            if (unit == '0) begin
                                n_stop = 1'b1;
                            end else if (unit >= HIGH_SURR_FIRST && unit <= HIGH_SURR_LAST) begin
                                n_skip   = SKIP_SURR;
                                emit     = 1'b1;
                                emit_len = LEN_UNIT32;
                            end else begin
                                emit     = 1'b1;
                                emit_len = LEN_UNIT16;
                            end
                        end else if (i_cfg.encoding == ENC_UTF32 && idx == UNIT_IDX_LAST32) begin
                            n_idx = '0;
                            if (gather == '0 && i_byte == '0) begin
                                n_stop = 1'b1;
                            end else begin
                                emit     = 1'b1;
                                emit_len = LEN_UNIT32;
                            end
                        end else begin
                            n_idx = idx + UNIT_IDX_W'(1);
                        end
                    end
                    default: begin
                    end
                endcase
            end
        end

        o_res.valid       = emit;
        o_res.char_offset = CHAR_OFFSET_W'(emit_off);
        o_res.char_length = emit_len;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_skip   <= '0;
            r_idx    <= '0;
            r_gather <= '0;
            r_ustart <= '0;
            r_stop   <= 1'b0;
        end else if (i_fire) begin
            r_pos    <= n_pos;
            r_skip   <= n_skip;
            r_idx    <= n_idx;
            r_gather <= n_gather;
            r_ustart <= n_ustart;
            r_stop   <= n_stop;
        end
    end

    a_len_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.char_length != 3'd0 && o_res.char_length != 3'd7))
        else $error("code point length out of range");

    a_stop_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_stop && !i_start) |-> !o_res.valid)
        else $error("result after end of string");

    a_skip_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != '0 && !i_start) |-> !o_res.valid)
        else $error("result while skipping trailing bytes");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && !i_start && r_pos == POS_MAX) |=> r_pos == POS_MAX)
        else $error("byte position wrapped");

endmodule
